/* rtl/ale_pkg.sv */
// ============================================================================
// ale_pkg - shared definitions for the array list engine
// Field widths, action and status codes, and the control/status structs
// that join the controller and the datapath.
// ============================================================================
package ale_pkg;

    // Field widths of the request and response
    localparam int ACTION_W = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 5;
    localparam int LEN_W    = 6;

    // Default list capacity
    localparam int DEF_CAPACITY = 32;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // Walk index load source
    typedef enum logic [1:0] {
        IDX_ZERO,
        IDX_POS,
        IDX_POS_P1,
        IDX_COUNT
    } idx_src_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic                latch;      // capture the request fields
        logic                idx_load;   // load walk index from idx_src
        idx_src_t            idx_src;
        logic                idx_inc;
        logic                idx_dec;
        logic                rd_en;      // read store at walk index
        logic                rd_shift;   // write read data back one slot over
        logic                shift_up;   // insert direction (read at index - 1)
        logic                wr_new;     // write request value at position
        logic                cnt_clr;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                found_load; // take address of matching read
        logic                rval_load;  // take read data as read value
        logic                res_load;   // load the response register
        logic [STATUS_W-1:0] res_status;
    } ale_ctrl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                pos_gt_cnt;
        logic                pos_ge_cnt;
        logic                full;
        logic                idx_gt_pos;
        logic                idx_lt_cnt;
        logic                match;
    } ale_stat_t;

endpackage

/* rtl/ale_if.sv */
// ============================================================================
// ale_if - request and response channels of the array list engine
// Valid/ready channels; a request or response moves on a clock edge where
// valid and ready are both high.
// ============================================================================

// Request channel
interface ale_cmd_if;
    import ale_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [POS_W-1:0]           position;
    logic signed [DATA_W-1:0]   data_value;

    modport source (output valid, output action, output position, output data_value,
                    input ready);
    modport sink   (input valid, input action, input position, input data_value,
                    output ready);
endinterface

// Response channel
interface ale_rsp_if;
    import ale_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [FOUND_W-1:0]         found_position;
    logic signed [DATA_W-1:0]   read_value;
    logic [LEN_W-1:0]           list_length;

    modport source (output valid, output status, output found_position,
                    output read_value, output list_length, input ready);
    modport sink   (input valid, input status, input found_position,
                    input read_value, input list_length, output ready);
endinterface

/* rtl/ale_datapath.sv */
// ============================================================================
// ale_datapath - list store, entry count, walk index and response register
// Store with one write port and a registered read port; shift writes follow
// their read in the next cycle, so a shift moves one entry per cycle.
// ============================================================================
module ale_datapath #(
    parameter int CAPACITY = ale_pkg::DEF_CAPACITY
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ale_pkg::ACTION_W-1:0]     action,
    input  logic [ale_pkg::POS_W-1:0]        position,
    input  logic signed [ale_pkg::DATA_W-1:0] data_value,
    input  ale_pkg::ale_ctrl_t               ctrl,
    output ale_pkg::ale_stat_t               stat,
    output logic [ale_pkg::STATUS_W-1:0]     status,
    output logic [ale_pkg::FOUND_W-1:0]      found_position,
    output logic signed [ale_pkg::DATA_W-1:0] read_value,
    output logic [ale_pkg::LEN_W-1:0]        list_length
);
    import ale_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LX_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int FX_W  = (IDX_W > FOUND_W) ? IDX_W : FOUND_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // List store
    logic [DATA_W-1:0]   mem [CAPACITY];

    // Latched request
    logic [ACTION_W-1:0] act_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [DATA_W-1:0]   val_reg;

    // Count, walk index, read pipeline
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                pend_rd_reg;
    logic                pend_wr_reg;
    logic                pend_up_reg;
    logic [IDX_W-1:0]    pend_addr_reg;
    logic [DATA_W-1:0]   rdata_reg;

    // Result collection and response register
    logic [IDX_W-1:0]    found_reg;
    logic [DATA_W-1:0]   rval_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [FOUND_W-1:0]  found_pos_reg;
    logic [DATA_W-1:0]   read_value_reg;
    logic [LEN_W-1:0]    length_reg;

    logic [CMP_W-1:0]    pos_ext, cnt_ext, idx_ext;
    logic [CNT_W-1:0]    idx_m1;
    logic [IDX_W-1:0]    raddr;
    logic                wr_en;
    logic [IDX_W-1:0]    waddr;
    logic [DATA_W-1:0]   wdata;
    logic [LX_W-1:0]     len_ext;
    logic [FX_W-1:0]     found_ext;

    // Compares for the controller
    always_comb
    begin
        pos_ext         = CMP_W'(pos_reg);
        cnt_ext         = CMP_W'(cnt_reg);
        idx_ext         = CMP_W'(idx_reg);
        stat.action     = act_reg;
        stat.pos_gt_cnt = (pos_ext > cnt_ext);
        stat.pos_ge_cnt = (pos_ext >= cnt_ext);
        stat.full       = (cnt_reg >= CAP_CNT);
        stat.idx_gt_pos = (idx_ext > pos_ext);
        stat.idx_lt_cnt = (idx_reg < cnt_reg);
        stat.match      = pend_rd_reg && (rdata_reg == val_reg);
    end

    // Store addressing: insert reads the entry below the walk index
    always_comb
    begin
        idx_m1 = idx_reg - CNT_W'(1);
        raddr  = ctrl.shift_up ? idx_m1[IDX_W-1:0] : idx_reg[IDX_W-1:0];
        wr_en  = pend_wr_reg || ctrl.wr_new;
        if (pend_wr_reg)
        begin
            waddr = pend_up_reg ? (pend_addr_reg + IDX_W'(1))
                                : (pend_addr_reg - IDX_W'(1));
            wdata = rdata_reg;
        end
        else
        begin
            waddr = pos_ext[IDX_W-1:0];
            wdata = val_reg;
        end
    end

    // Next walk index and count
    always_comb
    begin
        idx_next = idx_reg;
        if (ctrl.idx_load)
        begin
            case (ctrl.idx_src)
                IDX_ZERO:   idx_next = '0;
                IDX_POS:    idx_next = pos_ext[CNT_W-1:0];
                IDX_POS_P1: idx_next = pos_ext[CNT_W-1:0] + CNT_W'(1);
                IDX_COUNT:  idx_next = cnt_reg;
                default:    idx_next = '0;
            endcase
        end
        else if (ctrl.idx_inc)
            idx_next = idx_reg + CNT_W'(1);
        else if (ctrl.idx_dec)
            idx_next = idx_m1;

        cnt_next = cnt_reg;
        if (ctrl.cnt_clr)
            cnt_next = '0;
        else if (ctrl.cnt_inc)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (ctrl.cnt_dec)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    // Store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[waddr] <= wdata;
        if (ctrl.rd_en)
            rdata_reg <= mem[raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            idx_reg     <= '0;
            pend_rd_reg <= 1'b0;
            pend_wr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            pend_rd_reg <= ctrl.rd_en;
            pend_wr_reg <= ctrl.rd_en && ctrl.rd_shift;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_up_reg   <= ctrl.shift_up;
        pend_addr_reg <= raddr;
        if (ctrl.latch)
        begin
            act_reg  <= action;
            pos_reg  <= position;
            val_reg  <= data_value;
            found_reg <= '0;
            rval_reg  <= '0;
        end
        else
        begin
            if (ctrl.found_load)
                found_reg <= pend_addr_reg;
            if (ctrl.rval_load)
                rval_reg <= rdata_reg;
        end
        if (ctrl.res_load)
        begin
            status_reg     <= ctrl.res_status;
            found_pos_reg  <= found_ext[FOUND_W-1:0];
            read_value_reg <= rval_reg;
            length_reg     <= len_ext[LEN_W-1:0];
        end
    end

    // Response fields, masked to their widths
    assign len_ext        = LX_W'(cnt_reg);
    assign found_ext      = FX_W'(found_reg);
    assign status         = status_reg;
    assign found_position = found_pos_reg;
    assign read_value     = $signed(read_value_reg);
    assign list_length    = length_reg;

    // Checks
    a_wr_port_free: assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_wr_reg && ctrl.wr_new))
        else $error("shift write and new value write in the same cycle");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.cnt_inc |-> !stat.full)
        else $error("count incremented on a full list");

endmodule

/* rtl/ale_controller.sv */
// ============================================================================
// ale_controller - sequencer of the array list engine
// Decodes each request, walks the store for shifts, searches and reads,
// and hands the result to the response register.
// ============================================================================
module ale_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    input  ale_pkg::ale_stat_t   stat,
    output ale_pkg::ale_ctrl_t   ctrl
);
    import ale_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SHIFT,
        S_INS_PUT,
        S_DEL_SHIFT,
        S_SRCH,
        S_RD_ISSUE,
        S_RD_TAKE,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.latch = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                status_next = ST_OK;
                state_next  = S_DONE;
                case (stat.action)
                    ACT_CLEAR:
                        ctrl.cnt_clr = 1'b1;
                    ACT_INSERT:
                    begin
                        if (stat.pos_gt_cnt)
                            status_next = ST_BADPOS;
                        else if (stat.full)
                            status_next = ST_FULL;
                        else
                        begin
                            ctrl.idx_load = 1'b1;
                            ctrl.idx_src  = IDX_COUNT;
                            state_next    = S_INS_SHIFT;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (stat.pos_ge_cnt)
                            status_next = ST_BADPOS;
                        else
                        begin
                            ctrl.idx_load = 1'b1;
                            ctrl.idx_src  = IDX_POS_P1;
                            state_next    = S_DEL_SHIFT;
                        end
                    end
                    ACT_SEARCH:
                    begin
                        status_next   = ST_NOTFOUND;
                        ctrl.idx_load = 1'b1;
                        ctrl.idx_src  = IDX_ZERO;
                        state_next    = S_SRCH;
                    end
                    ACT_READ:
                    begin
                        if (stat.pos_ge_cnt)
                            status_next = ST_BADPOS;
                        else
                        begin
                            ctrl.idx_load = 1'b1;
                            ctrl.idx_src  = IDX_POS;
                            state_next    = S_RD_ISSUE;
                        end
                    end
                    default:
                        ; // unused codes: no change, status ok
                endcase
            end
            // Move entries up, top first; last move writes in the exit cycle
            S_INS_SHIFT:
            begin
                if (stat.idx_gt_pos)
                begin
                    ctrl.rd_en    = 1'b1;
                    ctrl.rd_shift = 1'b1;
                    ctrl.shift_up = 1'b1;
                    ctrl.idx_dec  = 1'b1;
                end
                else
                    state_next = S_INS_PUT;
            end
            S_INS_PUT:
            begin
                ctrl.wr_new  = 1'b1;
                ctrl.cnt_inc = 1'b1;
                state_next   = S_DONE;
            end
            // Move entries down, bottom first
            S_DEL_SHIFT:
            begin
                if (stat.idx_lt_cnt)
                begin
                    ctrl.rd_en    = 1'b1;
                    ctrl.rd_shift = 1'b1;
                    ctrl.idx_inc  = 1'b1;
                end
                else
                begin
                    ctrl.cnt_dec = 1'b1;
                    state_next   = S_DONE;
                end
            end
            // Compare each read in the cycle after it is issued
            S_SRCH:
            begin
                if (stat.match)
                begin
                    ctrl.found_load = 1'b1;
                    status_next     = ST_OK;
                    state_next      = S_DONE;
                end
                else if (stat.idx_lt_cnt)
                begin
                    ctrl.rd_en   = 1'b1;
                    ctrl.idx_inc = 1'b1;
                end
                else
                    state_next = S_DONE;
            end
            S_RD_ISSUE:
            begin
                ctrl.rd_en = 1'b1;
                state_next = S_RD_TAKE;
            end
            S_RD_TAKE:
            begin
                ctrl.rval_load = 1'b1;
                state_next     = S_DONE;
            end
            // Wait for the response register to be free
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.res_load  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        ctrl.res_status = status_reg;
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Checks
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside the done state");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && out_valid_reg && !out_ready |=> (state_reg == S_DONE))
        else $error("result dropped while response register busy");

    a_put_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_PUT) |-> $past(state_reg == S_INS_SHIFT))
        else $error("insert write without shift phase");

endmodule

/* rtl/array_list_engine.sv */
// ============================================================================
// array_list_engine - bounded ordered list with insert, delete, search, read
// Top level: controller plus datapath on valid/ready request and response
// channels.
// ============================================================================
// The list lives in a store of CAPACITY 32-bit entries with a write port and
// a registered read port; the store is not cleared at reset and needs no
// clearing pass. One request is worked at a time, and the next is taken
// while the previous response still waits in the output register. Clear,
// unused actions and rejected commands make no walk; insert and delete walk
// over the entries from the position to the end of the list, search walks
// up to the match, or over the whole list on a miss, and read fetches a
// single entry. A walk moves one entry per cycle through the store's ports,
// and the engine is ready for the next request in the same cycle that the
// response goes valid.
module array_list_engine #(
    parameter int CAPACITY = ale_pkg::DEF_CAPACITY
) (
    input  logic  clk,
    input  logic  rst_n,
    ale_cmd_if.sink   cmd,
    ale_rsp_if.source rsp
);
    import ale_pkg::*;

    ale_ctrl_t ctrl;
    ale_stat_t stat;

    // Sequencer
    ale_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Store, count and response register
    ale_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .action         (cmd.action),
        .position       (cmd.position),
        .data_value     (cmd.data_value),
        .ctrl           (ctrl),
        .stat           (stat),
        .status         (rsp.status),
        .found_position (rsp.found_position),
        .read_value     (rsp.read_value),
        .list_length    (rsp.list_length)
    );

endmodule
